@@ hdl/aoeu_pkg.sv @@
package aoeu_pkg;

  // element store
  localparam int ELEMENTS = 4096;
  localparam int IDX_W    = $clog2(ELEMENTS);

  // field and register widths
  localparam int ADDR_W = 12;
  localparam int WORD_W = 32;
  localparam int COEF_W = 24;
  localparam int POW_W  = 25;
  localparam int VM_W   = 64;

  // shared multiplier
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  // shared divide / root unit
  localparam int NUM_W  = 88;
  localparam int DIVR_W = 49;
  localparam int QUO_W  = 64;
  localparam int CNT_W  = 7;
  localparam int MHAT_W = 56;
  localparam int STEP_W = 41;

  localparam logic [CNT_W-1:0] STEPS_MHAT = 7'd56;
  localparam logic [CNT_W-1:0] STEPS_FULL = 7'd88;
  localparam logic [CNT_W-1:0] STEPS_ROOT = 7'd32;

  localparam logic [POW_W-1:0]  ONE_Q24    = 25'h1000000;
  localparam logic [COEF_W-1:0] HALF_Q24   = 24'h800000;
  localparam logic [STEP_W-1:0] STEP_LIMIT = 41'h10000000000;

  // configuration register indexes
  localparam logic [1:0] REG_LEARN_RATE = 2'd0;
  localparam logic [1:0] REG_BETA_ONE   = 2'd1;
  localparam logic [1:0] REG_BETA_TWO   = 2'd2;
  localparam logic [1:0] REG_STABILIZER = 2'd3;

  typedef struct packed {
    logic              start;
    logic              root_mode;
    logic [CNT_W-1:0]  steps;
    logic [NUM_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ hdl/aoeu_ram.sv @@
module aoeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/aoeu_mul.sv @@
module aoeu_mul (
  input  logic                                clk,
  input  logic signed [aoeu_pkg::MUL_W-1:0]  a,
  input  logic signed [aoeu_pkg::MUL_W-1:0]  b,
  output logic signed [aoeu_pkg::PROD_W-1:0] prod
);
  import aoeu_pkg::*;

  // registered signed product
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

@@ hdl/aoeu_divsqrt.sv @@
module aoeu_divsqrt (
  input  logic               clk,
  input  logic               rst,
  input  aoeu_pkg::div_req_t req,
  output aoeu_pkg::div_rsp_t rsp
);
  import aoeu_pkg::*;

  localparam int REM_W = DIVR_W + 2;

  logic              busy;
  logic              done;
  logic              root_mode;
  logic [CNT_W-1:0]  cnt;
  logic [NUM_W-1:0]  num;
  logic [DIVR_W-1:0] dvs;
  logic [REM_W-1:0]  rem;
  logic [QUO_W-1:0]  quo;
  logic              ovf;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic [REM_W:0]    diff;
  logic              ge;

  // one quotient bit (divide) or one root bit (two radicand bits) per cycle
  always_comb begin
    if (root_mode) begin
      rem_sh = {rem[REM_W-3:0], num[NUM_W-1 -: 2]};
      trial  = {quo[REM_W-3:0], 2'b01};
    end else begin
      rem_sh = {rem[REM_W-2:0], num[NUM_W-1]};
      trial  = REM_W'(dvs);
    end
    diff = {1'b0, rem_sh} - {1'b0, trial};
    ge   = !diff[REM_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy      <= 1'b1;
        root_mode <= req.root_mode;
        cnt       <= req.steps;
        num       <= req.dividend;
        dvs       <= req.divisor;
        rem       <= '0;
        quo       <= '0;
        ovf       <= 1'b0;
      end else if (busy) begin
        rem <= ge ? diff[REM_W-1:0] : rem_sh;
        quo <= {quo[QUO_W-2:0], ge};
        // a set bit pushed out of the quotient marks overflow
        ovf <= ovf | quo[QUO_W-1];
        num <= root_mode ? (num << 2) : (num << 1);
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.ovf  = ovf;
  assign rsp.quo  = quo;

endmodule

@@ hdl/adam_optimizer_element_update_unit.sv @@
// Fixed-point Adam update for one parameter element per request. A request with tuser low
// begins an optimizer step: the bias powers are scaled by beta_one and beta_two, with no
// result. A request with tuser high reads the first and second moments at the element
// address, blends in the gradient, writes the moments back, divides out the bias corrections,
// takes the square root, and returns weight - learn_rate * mhat / (sqrt(vhat) + stabilizer)
// saturated to Q16.16. An update before any step returns the weight unchanged with the error
// flag set. In a normal update one 34x34 multiplier is used for nine products, and one
// shift-subtract unit runs two divisions (56 and 88 steps), a 32-step square root and, after
// more products, a third division (88 steps), one bit per cycle. One request is processed
// at a time; s_axis_tready is low while it is in work, but a finished result may wait in the
// output register while the next request is taken. After reset the moment stores are cleared
// one entry per cycle with s_axis_tready low; configuration writes are taken at any time
// but should only be issued while the unit is idle.
module adam_optimizer_element_update_unit
  import aoeu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // element_address[11:0], weight_in[43:12], gradient[75:44]
  input  logic        s_axis_tuser,  // op
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // address_out[11:0], weight_out[43:12]
  output logic        m_axis_tuser   // error_flag
);

  localparam int ACC_W = 96;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_POW0, S_POW1, S_POW2,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8,
    S_DIV1, S_DIV2, S_ROOT,
    S_N0, S_N1, S_N2, S_N3, S_DIV3, S_WB, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [COEF_W-1:0] learn_rate;
  logic [COEF_W-1:0] beta_one;
  logic [COEF_W-1:0] beta_two;
  logic [WORD_W-1:0] stabilizer;

  // running bias powers, Q1.24 with one at bit 24
  logic [POW_W-1:0] pow_one;
  logic [POW_W-1:0] pow_two;

  // request capture and working registers
  logic [IDX_W-1:0]         clr_cnt;
  logic [ADDR_W-1:0]        addr_r;
  logic [IDX_W-1:0]         idx;
  logic signed [WORD_W-1:0] w_r;
  logic signed [WORD_W-1:0] g_r;
  logic signed [WORD_W-1:0] m_new;
  logic [VM_W-1:0]          y_sq;
  logic [VM_W-1:0]          v_new;
  logic [MHAT_W-1:0]        mhat;
  logic [DIVR_W-1:0]        denom;
  logic [STEP_W-1:0]        step;
  logic signed [ACC_W-1:0]  acc;
  logic signed [WORD_W-1:0] res_w;
  logic                     res_err;

  // output register
  logic              out_valid;
  logic [ADDR_W-1:0] out_addr;
  logic [WORD_W-1:0] out_w;
  logic              out_err;
  logic              out_load;

  // request fields
  logic [ADDR_W-1:0]        in_addr;
  logic signed [WORD_W-1:0] in_w;
  logic                     accept;

  assign in_addr = s_axis_tdata[11:0];
  assign in_w    = s_axis_tdata[43:12];
  assign s_axis_tready = (state == S_IDLE);
  assign accept  = s_axis_tvalid && s_axis_tready;

  // finished result moves into the output register once it is free
  assign out_load = (state == S_OUT) && (!out_valid || m_axis_tready);

  // moment stores
  logic                fm_we;
  logic [IDX_W-1:0]    fm_waddr;
  logic [WORD_W-1:0]   fm_wdata;
  logic [WORD_W-1:0]   fm_rdata;
  logic                sm_we;
  logic [IDX_W-1:0]    sm_waddr;
  logic [VM_W-1:0]     sm_wdata;
  logic [VM_W-1:0]     sm_rdata;

  // shared units
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // derived arithmetic terms
  logic [POW_W-1:0]         comp_one;    // 1 - beta_one
  logic [POW_W-1:0]         comp_two;    // 1 - beta_two
  logic [POW_W-1:0]         corr_one;    // 1 - beta_one_power
  logic [POW_W-1:0]         corr_two;    // 1 - beta_two_power, at least one lsb
  logic [WORD_W-1:0]        abs_g;
  logic [WORD_W-1:0]        abs_m;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  prod_hi;
  logic                     m_fits;
  logic signed [WORD_W-1:0] m_sat;
  logic [VM_W-1:0]          vhat;
  logic [DIVR_W-1:0]        denom_sum;
  logic signed [STEP_W+1:0] w_sum;
  logic                     w_fits;

  assign comp_one = ONE_Q24 - {1'b0, beta_one};
  assign comp_two = ONE_Q24 - {1'b0, beta_two};
  assign corr_one = ONE_Q24 - pow_one;
  assign corr_two = pow_two[POW_W-1] ? POW_W'(1) : (ONE_Q24 - pow_two);
  assign abs_g    = g_r[WORD_W-1] ? (WORD_W'(0) - g_r) : g_r;
  assign abs_m    = m_new[WORD_W-1] ? (WORD_W'(0) - m_new) : m_new;

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign prod_hi  = {prod_ext[ACC_W-33:0], 32'b0};

  // new first moment: floor shift by 24 then clamp to 32 bits signed
  assign m_fits = (acc[ACC_W-1:55] == {(ACC_W-55){acc[ACC_W-1]}});
  assign m_sat  = m_fits ? acc[55:24] : (acc[ACC_W-1] ? 32'sh80000000 : 32'sh7fffffff);

  // bias-corrected second moment, all ones when the quotient overflows
  assign vhat = div_rsp.ovf ? {VM_W{1'b1}} : div_rsp.quo;

  assign denom_sum = {div_rsp.quo[WORD_W-1:0], 16'b0} + DIVR_W'(stabilizer);

  // weight moves against the sign of the first moment
  assign w_sum  = m_new[WORD_W-1] ? ((STEP_W+2)'(w_r) + (STEP_W+2)'({1'b0, step}))
                                  : ((STEP_W+2)'(w_r) - (STEP_W+2)'({1'b0, step}));
  assign w_fits = (w_sum[STEP_W+1:WORD_W-1] == {(STEP_W-WORD_W+3){w_sum[STEP_W+1]}});

  // multiplier operand select; the product is registered and used in the state that follows
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_POW0: begin
        mul_a = MUL_W'(pow_one);
        mul_b = MUL_W'(beta_one);
      end
      S_POW1: begin
        mul_a = MUL_W'(pow_two);
        mul_b = MUL_W'(beta_two);
      end
      S_M0: begin
        mul_a = MUL_W'(beta_one);
        mul_b = {{(MUL_W-WORD_W){fm_rdata[WORD_W-1]}}, fm_rdata};
      end
      S_M1: begin
        mul_a = MUL_W'(comp_one);
        mul_b = {{(MUL_W-WORD_W){g_r[WORD_W-1]}}, g_r};
      end
      S_M2: begin
        mul_a = MUL_W'(abs_g);
        mul_b = MUL_W'(abs_g);
      end
      S_M3: begin
        mul_a = MUL_W'(beta_two);
        mul_b = MUL_W'(sm_rdata[31:0]);
      end
      S_M4: begin
        mul_a = MUL_W'(beta_two);
        mul_b = MUL_W'(sm_rdata[63:32]);
      end
      S_M5: begin
        mul_a = MUL_W'(comp_two);
        mul_b = MUL_W'(y_sq[31:0]);
      end
      S_M6: begin
        mul_a = MUL_W'(comp_two);
        mul_b = MUL_W'(y_sq[63:32]);
      end
      S_N0: begin
        mul_a = MUL_W'(mhat[31:0]);
        mul_b = MUL_W'(learn_rate);
      end
      S_N1: begin
        mul_a = MUL_W'(mhat[MHAT_W-1:32]);
        mul_b = MUL_W'(learn_rate);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divide / root unit requests
  always_comb begin
    div_req = '0;
    case (state)
      S_M8: begin
        // |mhat| = |m| * 2^24 / corr_one
        div_req.start    = 1'b1;
        div_req.steps    = STEPS_MHAT;
        div_req.dividend = {abs_m, 56'b0};
        div_req.divisor  = DIVR_W'(corr_one);
      end
      S_DIV1: begin
        // vhat = v * 2^24 / corr_two
        div_req.start    = div_rsp.done;
        div_req.steps    = STEPS_FULL;
        div_req.dividend = {v_new, 24'b0};
        div_req.divisor  = DIVR_W'(corr_two);
      end
      S_DIV2: begin
        div_req.start     = div_rsp.done;
        div_req.root_mode = 1'b1;
        div_req.steps     = STEPS_ROOT;
        div_req.dividend  = {vhat, 24'b0};
      end
      S_N3: begin
        // step = |mhat| * learn_rate * 2^8 / denom
        div_req.start    = 1'b1;
        div_req.steps    = STEPS_FULL;
        div_req.dividend = {acc[79:0], 8'b0};
        div_req.divisor  = denom;
      end
      default: div_req = '0;
    endcase
  end

  // store writes: clearing sweep, then write-back of the blended moments
  always_comb begin
    fm_we    = (state == S_CLEAR) || (state == S_M3);
    fm_waddr = (state == S_CLEAR) ? clr_cnt : idx;
    fm_wdata = (state == S_CLEAR) ? '0 : m_sat;
    sm_we    = (state == S_CLEAR) || (state == S_M8);
    sm_waddr = (state == S_CLEAR) ? clr_cnt : idx;
    sm_wdata = (state == S_CLEAR) ? '0 : acc[87:24];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
      learn_rate <= 24'd16777;
      beta_one   <= 24'd15099494;
      beta_two   <= 24'd16760439;
      stabilizer <= 32'd43;
      pow_one    <= ONE_Q24;
      pow_two    <= ONE_Q24;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEARN_RATE: learn_rate <= cfg_data[COEF_W-1:0];
          REG_BETA_ONE:   beta_one   <= cfg_data[COEF_W-1:0];
          REG_BETA_TWO:   beta_two   <= cfg_data[COEF_W-1:0];
          REG_STABILIZER: stabilizer <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + IDX_W'(1);
          if (clr_cnt == {IDX_W{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            addr_r <= in_addr;
            idx    <= IDX_W'(in_addr);
            w_r    <= in_w;
            g_r    <= s_axis_tdata[75:44];
            if (!s_axis_tuser) begin
              state <= S_POW0;
            end else if (pow_one[POW_W-1]) begin
              // no step begun yet: echo the weight with the error flag
              res_w   <= in_w;
              res_err <= 1'b1;
              state   <= S_OUT;
            end else begin
              state <= S_M0;
            end
          end
        end
        S_POW0: state <= S_POW1;
        S_POW1: begin
          pow_one <= prod[48:24];
          state   <= S_POW2;
        end
        S_POW2: begin
          pow_two <= prod[48:24];
          state   <= S_IDLE;
        end
        // first moment: beta_one * m + (1 - beta_one) * g, rounded
        S_M0: state <= S_M1;
        S_M1: begin
          acc   <= prod_ext + ACC_W'(HALF_Q24);
          state <= S_M2;
        end
        S_M2: begin
          acc   <= acc + prod_ext;
          state <= S_M3;
        end
        S_M3: begin
          m_new <= m_sat;
          y_sq  <= prod[VM_W-1:0];
          state <= S_M4;
        end
        // second moment: beta_two * v + (1 - beta_two) * g^2, rounded
        S_M4: begin
          acc   <= prod_ext + ACC_W'(HALF_Q24);
          state <= S_M5;
        end
        S_M5: begin
          acc   <= acc + prod_hi;
          state <= S_M6;
        end
        S_M6: begin
          acc   <= acc + prod_ext;
          state <= S_M7;
        end
        S_M7: begin
          acc   <= acc + prod_hi;
          state <= S_M8;
        end
        S_M8: begin
          v_new <= acc[87:24];
          state <= S_DIV1;
        end
        S_DIV1: begin
          if (div_rsp.done) begin
            mhat  <= div_rsp.quo[MHAT_W-1:0];
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_rsp.done) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (div_rsp.done) begin
            denom <= (denom_sum == '0) ? DIVR_W'(1) : denom_sum;
            state <= S_N0;
          end
        end
        S_N0: state <= S_N1;
        S_N1: begin
          acc   <= prod_ext;
          state <= S_N2;
        end
        S_N2: begin
          acc   <= acc + prod_hi;
          state <= S_N3;
        end
        S_N3: state <= S_DIV3;
        S_DIV3: begin
          if (div_rsp.done) begin
            step  <= (div_rsp.ovf || (div_rsp.quo > QUO_W'(STEP_LIMIT)))
                     ? STEP_LIMIT : div_rsp.quo[STEP_W-1:0];
            state <= S_WB;
          end
        end
        S_WB: begin
          res_w   <= w_fits ? w_sum[WORD_W-1:0]
                            : (w_sum[STEP_W+1] ? 32'sh80000000 : 32'sh7fffffff);
          res_err <= 1'b0;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_addr  <= addr_r;
            out_w     <= res_w;
            out_err   <= res_err;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, out_w, out_addr};
  assign m_axis_tuser  = out_err;

  aoeu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ELEMENTS)
  ) u_first_moment (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .re    (accept),
    .raddr (IDX_W'(in_addr)),
    .rdata (fm_rdata)
  );

  aoeu_ram #(
    .WIDTH (VM_W),
    .DEPTH (ELEMENTS)
  ) u_second_moment (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .re    (accept),
    .raddr (IDX_W'(in_addr)),
    .rdata (sm_rdata)
  );

  aoeu_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  aoeu_divsqrt u_divsqrt (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

`ifndef SYNTHESIS
  // no request is taken while the stores are being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_axis_tready)
    else $error("request ready during store clear");

  // the divide unit only finishes while the sequencer waits for it
  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV1 || state == S_DIV2 || state == S_ROOT ||
                      state == S_DIV3))
    else $error("divide unit finished outside a wait state");

  // an update before any step goes straight to the output stage
  a_early_update: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tuser && pow_one[POW_W-1]) |=> (state == S_OUT))
    else $error("early update did not short-cut to output");

  // a finished result is held while the output register is still occupied
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !m_axis_tready) |=> (state == S_OUT))
    else $error("result dropped while output stalled");
`endif

endmodule
